### src/pwp_pkg.sv
// Package for the protocol-buffer wire parser: phase and event codes, result record.
// Used by every module under src; depends on nothing.
package pwp_pkg;

    localparam int DataW   = 8;
    localparam int FieldW  = 61;
    localparam int ValueW  = 64;
    localparam int ShiftW  = 7;
    localparam int KindW   = 3;
    localparam int EventW  = 3;
    // field_number + value + payload_byte + payload_last, padded to whole bytes
    localparam int MDataW  = ((FieldW + ValueW + DataW + 1 + 7) / 8) * 8;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARVAL  = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SKIP    = 3'd5
    } phase_t;

    typedef enum logic [EventW-1:0] {
        EV_VARINT  = 3'd0,
        EV_FIXED64 = 3'd1,
        EV_FIXED32 = 3'd2,
        EV_PAYLOAD = 3'd3,
        EV_EMPTY   = 3'd4,
        EV_TRUNC   = 3'd5,
        EV_BADTYPE = 3'd6
    } event_t;

    localparam logic [KindW-1:0] WT_VARINT  = 3'd0;
    localparam logic [KindW-1:0] WT_FIXED64 = 3'd1;
    localparam logic [KindW-1:0] WT_LEN     = 3'd2;
    localparam logic [KindW-1:0] WT_FIXED32 = 3'd5;

    typedef struct packed {
        event_t              ev;
        logic [FieldW-1:0]   field_number;
        logic [ValueW-1:0]   value;
        logic [DataW-1:0]    payload_byte;
        logic                payload_last;
        logic                message_end;
    } res_t;

    typedef struct packed {
        logic [DataW-1:0] data_byte;
        logic             message_end;
    } item_t;

endpackage

### src/pwp_in_reg.sv
// Input register of the wire parser: holds one byte item until the decoder takes it.
// Depends on pwp_pkg.
module pwp_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pwp_pkg::item_t s_item,
    input  logic          take,
    output logic          item_valid,
    output pwp_pkg::item_t item
);
    import pwp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### src/pwp_core.sv
// Decoder state and per-byte decode logic of the wire parser.
// Depends on pwp_pkg.
module pwp_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           take,
    input  pwp_pkg::item_t item,
    output logic           res_valid,
    output pwp_pkg::res_t  res
);
    import pwp_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [ValueW-1:0]   acc_reg, acc_next;
    logic [ShiftW-1:0]   shift_reg, shift_next;
    logic [KindW-1:0]    kind_reg, kind_next;
    logic [FieldW-1:0]   field_reg, field_next;
    logic [ValueW-1:0]   remain_reg, remain_next;
    logic [ValueW-1:0]   strlen_reg, strlen_next;

    logic [ValueW-1:0]   acc_vi;
    logic [ValueW-1:0]   acc_fx;
    logic [ShiftW-1:0]   shift_vi;
    logic [ShiftW-1:0]   shift_fx;
    logic [ValueW-1:0]   remain_dec;
    logic                in_range;
    logic                last;
    logic [DataW-1:0]    b;

    assign b        = item.data_byte;
    assign last     = item.message_end;
    // groups at offset 64 or beyond drop away
    assign in_range = !shift_reg[ShiftW-1];
    assign acc_vi   = in_range
        ? (acc_reg | ({{(ValueW-7){1'b0}}, b[6:0]} << shift_reg[ShiftW-2:0])) : acc_reg;
    assign acc_fx   = in_range
        ? (acc_reg | ({{(ValueW-DataW){1'b0}}, b} << shift_reg[ShiftW-2:0])) : acc_reg;
    assign shift_vi = in_range ? shift_reg + ShiftW'(7) : shift_reg;
    assign shift_fx = in_range ? shift_reg + ShiftW'(8) : shift_reg;
    assign remain_dec = (remain_reg != '0) ? remain_reg - ValueW'(1) : remain_reg;

    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        kind_next   = kind_reg;
        field_next  = field_reg;
        remain_next = remain_reg;
        strlen_next = strlen_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.field_number = field_reg;

        unique case (phase_reg)
            PH_TAG, PH_VARVAL, PH_LEN: begin
                if (b[7]) begin
                    acc_next   = acc_vi;
                    shift_next = shift_vi;
                    if (last) begin
                        res_valid = 1'b1;
                        res.ev    = EV_TRUNC;
                        if (phase_reg == PH_TAG) begin
                            res.field_number = '0;
                        end
                    end
                end else begin
                    acc_next   = '0;
                    shift_next = '0;
                    if (phase_reg == PH_TAG) begin
                        field_next       = acc_vi[ValueW-1:3];
                        kind_next        = acc_vi[2:0];
                        res.field_number = acc_vi[ValueW-1:3];
                        priority if (acc_vi[2:0] == WT_VARINT) begin
                            phase_next = PH_VARVAL;
                        end else if (acc_vi[2:0] == WT_FIXED64) begin
                            phase_next  = PH_FIXED;
                            remain_next = ValueW'(8);
                        end else if (acc_vi[2:0] == WT_FIXED32) begin
                            phase_next  = PH_FIXED;
                            remain_next = ValueW'(4);
                        end else if (acc_vi[2:0] == WT_LEN) begin
                            phase_next = PH_LEN;
                        end else begin
                            phase_next = PH_SKIP;
                            res_valid  = 1'b1;
                            res.ev     = EV_BADTYPE;
                        end
                        if (last && !res_valid) begin
                            res_valid = 1'b1;
                            res.ev    = EV_TRUNC;
                        end
                    end else if (phase_reg == PH_VARVAL) begin
                        phase_next = PH_TAG;
                        res_valid  = 1'b1;
                        res.ev     = EV_VARINT;
                        res.value  = acc_vi;
                    end else if (acc_vi == '0) begin
                        phase_next = PH_TAG;
                        res_valid  = 1'b1;
                        res.ev     = EV_EMPTY;
                    end else begin
                        strlen_next = acc_vi;
                        remain_next = acc_vi;
                        phase_next  = PH_PAYLOAD;
                        if (last) begin
                            res_valid = 1'b1;
                            res.ev    = EV_TRUNC;
                        end
                    end
                end
            end
            PH_FIXED: begin
                acc_next    = acc_fx;
                shift_next  = shift_fx;
                remain_next = remain_dec;
                if (remain_dec == '0) begin
                    acc_next   = '0;
                    shift_next = '0;
                    phase_next = PH_TAG;
                    res_valid  = 1'b1;
                    res.ev     = (kind_reg == WT_FIXED64) ? EV_FIXED64 : EV_FIXED32;
                    res.value  = acc_fx;
                end else if (last) begin
                    res_valid = 1'b1;
                    res.ev    = EV_TRUNC;
                end
            end
            PH_PAYLOAD: begin
                remain_next = remain_dec;
                res_valid   = 1'b1;
                if (remain_dec == '0) begin
                    phase_next       = PH_TAG;
                    res.ev           = EV_PAYLOAD;
                    res.value        = strlen_reg;
                    res.payload_byte = b;
                    res.payload_last = 1'b1;
                end else if (last) begin
                    res.ev = EV_TRUNC;
                end else begin
                    res.ev           = EV_PAYLOAD;
                    res.value        = strlen_reg;
                    res.payload_byte = b;
                end
            end
            default: begin
                // skipping after a bad wire type: drop the byte
            end
        endcase

        res.message_end = last;

        // every message end returns the decoder to its reset state
        if (last) begin
            phase_next  = PH_TAG;
            acc_next    = '0;
            shift_next  = '0;
            kind_next   = '0;
            field_next  = '0;
            remain_next = '0;
            strlen_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TAG;
            acc_reg    <= '0;
            shift_reg  <= '0;
            kind_reg   <= '0;
            field_reg  <= '0;
            remain_reg <= '0;
            strlen_reg <= '0;
        end else if (take) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            shift_reg  <= shift_next;
            kind_reg   <= kind_next;
            field_reg  <= field_next;
            remain_reg <= remain_next;
            strlen_reg <= strlen_next;
        end
    end

endmodule

### src/pwp_out_reg.sv
// Result register of the wire parser: holds one result item until the sink takes it.
// Depends on pwp_pkg.
module pwp_out_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  pwp_pkg::res_t res_in,
    output logic          free,
    output logic          m_valid,
    input  logic          m_ready,
    output pwp_pkg::res_t m_res
);
    import pwp_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

### src/protobuf_wire_parser_top.sv
// Channel   | Dir | tdata                                   | tuser     | tlast
// s_axis    | in  | data_byte[7:0]                          | -         | message_end
// m_axis    | out | field_number, value, payload_byte, last | event_res | message_end_res
//
// One byte item per cycle sustained while m_axis does not stall: the input register
// feeds the decode logic, which writes the result register and the decoder state in
// the same cycle. m_axis sees a byte's result after the input and result registers.
// Reset (aresetn low, synchronous) empties both registers and starts a new message.
// An m_axis stall holds the result register; the input register then holds one
// more item, and s_axis_tready drops until the result is taken.
// Depends on pwp_pkg, pwp_in_reg, pwp_core, pwp_out_reg.
module protobuf_wire_parser_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [pwp_pkg::DataW-1:0]   s_axis_tdata,  // [7:0] data_byte
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [60:0] field_number, [124:61] value, [132:125] payload_byte,
    // [133] payload_last, [135:134] zero
    output logic [pwp_pkg::MDataW-1:0]  m_axis_tdata,
    output logic [pwp_pkg::EventW-1:0]  m_axis_tuser,  // [2:0] event_res
    output logic                        m_axis_tlast
);
    import pwp_pkg::*;

    item_t s_item;
    item_t item;
    logic  item_valid;
    logic  take;
    logic  out_free;
    logic  res_valid;
    res_t  res;
    res_t  m_res;

    assign s_item.data_byte   = s_axis_tdata;
    assign s_item.message_end = s_axis_tlast;

    // advance the held byte whenever the result register can take its outcome
    assign take = item_valid && out_free;

    pwp_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    pwp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    pwp_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (take && res_valid),
        .res_in  (res),
        .free    (out_free),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_res   (m_res)
    );

    assign m_axis_tdata = {{(MDataW-FieldW-ValueW-DataW-1){1'b0}}, m_res.payload_last,
                           m_res.payload_byte, m_res.value, m_res.field_number};
    assign m_axis_tuser = m_res.ev;
    assign m_axis_tlast = m_res.message_end;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for protobuf_wire_parser_top: feeds encoded messages byte by byte
// on s_axis and checks each m_axis result against a decoder model held in the bench.
// Depends on pwp_pkg and the parser RTL under src; reads no files.
module tb;
    import pwp_pkg::*;

    // Wire types the parser rejects
    localparam logic [KindW-1:0] WT_SGROUP = 3'd3;
    localparam logic [KindW-1:0] WT_EGROUP = 3'd4;
    localparam logic [KindW-1:0] WT_RSVD6  = 3'd6;
    localparam logic [KindW-1:0] WT_RSVD7  = 3'd7;

    localparam int HalfPeriod = 6;
    localparam int HoldCycles = 400;
    localparam int TimeoutNs  = 2_000_000;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DataW-1:0]  s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [MDataW-1:0] m_axis_tdata;
    logic [EventW-1:0] m_axis_tuser;
    logic              m_axis_tlast;

    protobuf_wire_parser_top DUT (.*);

    always #(HalfPeriod) aclk = ~aclk;

    // Decoder model state
    phase_t            dec_phase     = PH_TAG;
    logic [ValueW-1:0] dec_acc       = '0;
    logic [ShiftW-1:0] dec_shift     = '0;
    logic [KindW-1:0]  dec_kind      = '0;
    logic [FieldW-1:0] dec_field     = '0;
    logic [ValueW-1:0] dec_remaining = '0;
    logic [ValueW-1:0] dec_strlen    = '0;

    res_t       events_due[$];
    logic [7:0] msg_bytes[$];

    int fault_count   = 0;
    int bytes_sent    = 0;
    int messages_sent = 0;
    int results_seen  = 0;
    int input_stalls  = 0;
    int ev_seen[7];

    bit quiet        = 1'b0;
    bit hold_request = 1'b0;
    int hold_left    = 0;

    function automatic void clear_decoder();
        dec_phase     = PH_TAG;
        dec_acc       = '0;
        dec_shift     = '0;
        dec_kind      = '0;
        dec_field     = '0;
        dec_remaining = '0;
        dec_strlen    = '0;
    endfunction

    // Advance the decoder by one accepted byte and queue the event it yields, if any
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        res_t        r;
        logic        found;
        logic [63:0] v;
        r     = '0;
        found = 1'b0;
        v     = '0;
        case (dec_phase)
            PH_TAG, PH_VARVAL, PH_LEN: begin
                // groups at offset 64 and beyond fall away
                if (dec_shift < 64) begin
                    dec_acc   |= {57'd0, b[6:0]} << dec_shift;
                    dec_shift += 7;
                end
                if (b[7]) begin
                    if (last) begin
                        found          = 1'b1;
                        r.ev           = EV_TRUNC;
                        r.field_number = (dec_phase == PH_TAG) ? '0 : dec_field;
                    end
                end else begin
                    v         = dec_acc;
                    dec_acc   = '0;
                    dec_shift = '0;
                    if (dec_phase == PH_TAG) begin
                        dec_field = v[63:3];
                        dec_kind  = v[2:0];
                        case (dec_kind)
                            WT_VARINT: dec_phase = PH_VARVAL;
                            WT_FIXED64, WT_FIXED32: begin
                                dec_phase     = PH_FIXED;
                                dec_remaining = (dec_kind == WT_FIXED64) ? 64'd8 : 64'd4;
                            end
                            WT_LEN: dec_phase = PH_LEN;
                            default: begin
                                dec_phase      = PH_SKIP;
                                found          = 1'b1;
                                r.ev           = EV_BADTYPE;
                                r.field_number = dec_field;
                            end
                        endcase
                        if (last && !found) begin
                            found          = 1'b1;
                            r.ev           = EV_TRUNC;
                            r.field_number = dec_field;
                        end
                    end else if (dec_phase == PH_VARVAL) begin
                        dec_phase      = PH_TAG;
                        found          = 1'b1;
                        r.ev           = EV_VARINT;
                        r.field_number = dec_field;
                        r.value        = v;
                    end else if (v == 0) begin
                        dec_phase      = PH_TAG;
                        found          = 1'b1;
                        r.ev           = EV_EMPTY;
                        r.field_number = dec_field;
                    end else begin
                        dec_strlen    = v;
                        dec_remaining = v;
                        dec_phase     = PH_PAYLOAD;
                        if (last) begin
                            found          = 1'b1;
                            r.ev           = EV_TRUNC;
                            r.field_number = dec_field;
                        end
                    end
                end
            end
            PH_FIXED: begin
                if (dec_shift < 64) begin
                    dec_acc   |= {56'd0, b} << dec_shift;
                    dec_shift += 8;
                end
                if (dec_remaining != 0)
                    dec_remaining--;
                r.field_number = dec_field;
                if (dec_remaining == 0) begin
                    found     = 1'b1;
                    r.ev      = (dec_kind == WT_FIXED64) ? EV_FIXED64 : EV_FIXED32;
                    r.value   = dec_acc;
                    dec_acc   = '0;
                    dec_shift = '0;
                    dec_phase = PH_TAG;
                end else if (last) begin
                    found = 1'b1;
                    r.ev  = EV_TRUNC;
                end
            end
            PH_PAYLOAD: begin
                if (dec_remaining != 0)
                    dec_remaining--;
                found          = 1'b1;
                r.field_number = dec_field;
                if (dec_remaining == 0) begin
                    dec_phase      = PH_TAG;
                    r.ev           = EV_PAYLOAD;
                    r.value        = dec_strlen;
                    r.payload_byte = b;
                    r.payload_last = 1'b1;
                end else if (last) begin
                    r.ev = EV_TRUNC;
                end else begin
                    r.ev           = EV_PAYLOAD;
                    r.value        = dec_strlen;
                    r.payload_byte = b;
                end
            end
            default: ;  // skipping to the message end: drop the byte
        endcase
        if (found) begin
            r.message_end = last;
            events_due.insert(events_due.size(), r);
        end
        if (last)
            clear_decoder();
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser < 7)
                ev_seen[m_axis_tuser]++;
            if (events_due.size() == 0) begin
                $error("result with no event pending: event_res %0d", m_axis_tuser);
                fault_count++;
            end else begin
                want = events_due.pop_front();
                check_field("event_res", 64'(want.ev), 64'(m_axis_tuser));
                check_field("field_number", 64'(want.field_number), 64'(m_axis_tdata[60:0]));
                check_field("value", want.value, m_axis_tdata[124:61]);
                check_field("payload_byte", 64'(want.payload_byte),
                            64'(m_axis_tdata[132:125]));
                check_field("payload_last", 64'(want.payload_last), 64'(m_axis_tdata[133]));
                check_field("message_end_res", 64'(want.message_end), 64'(m_axis_tlast));
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HoldCycles;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = quiet || ($urandom_range(99) >= 9);
        end
    end

    // Called and returns at a falling edge; valid is low again on return
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet)
            while ($urandom_range(99) < 9) begin
                s_axis_tvalid = 1'b0;
                @(negedge aclk);
            end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        @(posedge aclk);
        while (!s_axis_tready) begin
            input_stalls++;
            @(posedge aclk);
        end
        decode_byte(b, last);
        bytes_sent++;
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    // Append one byte to the message being built
    function automatic void append_byte(input logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    // pad adds continuation groups with random content after the value
    function automatic void put_varint(input logic [63:0] v, input int pad);
        logic [63:0] rest;
        rest = v;
        while (rest > 127) begin
            append_byte({1'b1, rest[6:0]});
            rest >>= 7;
        end
        repeat (pad) begin
            append_byte({1'b1, rest[6:0]});
            rest = 64'($urandom_range(127));
        end
        append_byte({1'b0, rest[6:0]});
    endfunction

    function automatic void put_tag(input logic [FieldW-1:0] fn, input logic [KindW-1:0] kind);
        put_varint({fn, kind}, 0);
    endfunction

    function automatic void put_fixed(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            append_byte(v[8*i +: 8]);
    endfunction

    function automatic logic [FieldW-1:0] pick_field();
        case ($urandom_range(9))
            0:       return '1;
            1:       return FieldW'({$urandom, $urandom});
            default: return FieldW'($urandom_range(31));
        endcase
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0:       return '1;
            1:       return '0;
            default: return v >> $urandom_range(63);
        endcase
    endfunction

    function automatic void add_random_field();
        logic [FieldW-1:0] fn;
        int                pick;
        int                n;
        fn   = pick_field();
        pick = $urandom_range(99);
        if (pick < 30) begin
            put_tag(fn, WT_VARINT);
            put_varint(pick_value(), ($urandom_range(9) == 0) ? $urandom_range(1, 10) : 0);
        end else if (pick < 45) begin
            put_tag(fn, WT_FIXED64);
            put_fixed(pick_value(), 8);
        end else if (pick < 60) begin
            put_tag(fn, WT_FIXED32);
            put_fixed(pick_value(), 4);
        end else if (pick < 95) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
            put_tag(fn, WT_LEN);
            put_varint(64'(n), 0);
            repeat (n) append_byte(8'($urandom));
        end else begin
            case ($urandom_range(3))
                0:       put_tag(fn, WT_SGROUP);
                1:       put_tag(fn, WT_EGROUP);
                2:       put_tag(fn, WT_RSVD6);
                default: put_tag(fn, WT_RSVD7);
            endcase
        end
    endfunction

    // Send the built message, optionally cut short, with tlast on its final byte
    task automatic send_message(input bit cut);
        int n;
        n = msg_bytes.size();
        if (cut && n > 1)
            n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++)
            send_byte(msg_bytes[i], i == n - 1);
        msg_bytes.delete();
        messages_sent++;
    endtask

    task automatic test_each_wire_type();
        put_tag(1, WT_VARINT);
        put_varint(0, 0);
        put_tag(1, WT_FIXED64);
        put_fixed('1, 8);
        put_tag(2, WT_FIXED32);
        put_fixed(64'h8000_0001, 4);
        put_tag(3, WT_LEN);
        put_varint(0, 0);
        put_tag(4, WT_LEN);
        put_varint(1, 0);
        append_byte(8'hFF);
        send_message(0);
    endtask

    task automatic test_bad_wire_type();
        put_tag(5, WT_SGROUP);
        put_tag(1, WT_VARINT);
        put_varint(7, 0);
        send_message(0);
    endtask

    task automatic test_truncation();
        // unfinished tag, then a complete tag with nothing after it
        append_byte(8'h80);
        send_message(0);
        put_tag(9, WT_VARINT);
        send_message(0);
    endtask

    task automatic test_varint_wrap();
        put_tag(15, WT_VARINT);
        repeat (9) append_byte(8'hFF);
        // offset 63 keeps only its lowest bit; later groups fall away
        append_byte(8'hFE);
        append_byte(8'hFF);
        append_byte(8'h01);
        send_message(0);
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        put_tag(6, WT_LEN);
        put_varint(24, 0);
        repeat (24) append_byte(8'($urandom));
        send_message(0);
    endtask

    task automatic test_random_messages(input int byte_budget);
        int goal;
        int pick;
        goal = bytes_sent + byte_budget;
        while (bytes_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
                send_message(0);
            end else begin
                repeat ($urandom_range(1, 4)) add_random_field();
                send_message(pick < 20);
            end
        end
    endtask

    task automatic test_back_to_back(input int byte_budget);
        quiet = 1'b1;
        test_random_messages(byte_budget);
        quiet = 1'b0;
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        test_each_wire_type();
        test_bad_wire_type();
        test_truncation();
        test_varint_wrap();
        test_backpressure();
        test_back_to_back(80);
        test_random_messages(250);
        while (events_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("Sent %0d messages (%0d bytes), checked %0d results, input stalled %0d cycles.",
                 messages_sent, bytes_sent, results_seen, input_stalls);
        $display("Events: varint %0d, fixed64 %0d, fixed32 %0d, payload %0d, empty %0d, %s %0d, %s %0d",
                 ev_seen[EV_VARINT], ev_seen[EV_FIXED64], ev_seen[EV_FIXED32],
                 ev_seen[EV_PAYLOAD], ev_seen[EV_EMPTY], "truncated", ev_seen[EV_TRUNC],
                 "bad type", ev_seen[EV_BADTYPE]);
        if (fault_count == 0)
            $display("protobuf_wire_parser_top verification clean");
        else
            $display("protobuf_wire_parser_top verification failed");
        $finish;
    end

    initial begin
        #(TimeoutNs);
        $display("protobuf_wire_parser_top verification failed");
        $finish;
    end

endmodule
